@@ rtl/stiu_pkg.sv @@
// package for the segment / triangle intersection unit
// transaction payload types and fixed field widths; no dependencies
`timescale 1ns / 1ps
package stiu_pkg;

    // signed coordinate width, three coordinates per packed point
    localparam int COORD_BITS = 16;
    // packed point field width (x, y, z coordinates)
    localparam int POINT_W = 3 * COORD_BITS;
    // fraction precision of the reported hit position
    localparam int FRACTION_BITS = 16;
    localparam int FRAC_W = FRACTION_BITS + 1;

    typedef struct packed {
        logic [POINT_W-1:0] seg_start;
        logic [POINT_W-1:0] seg_end;
        logic [POINT_W-1:0] vert_a;
        logic [POINT_W-1:0] vert_b;
        logic [POINT_W-1:0] vert_c;
    } t_in_item;

    typedef struct packed {
        logic              hit;
        logic [FRAC_W-1:0] hit_fraction;
    } t_out_item;

endpackage

@@ rtl/stiu_front.sv @@
// front part: unpacks coordinates, forms edge vectors and both cross products
// depends on stiu_pkg
`timescale 1ns / 1ps
module stiu_front #(
    parameter int COORD_BITS = 16,
    parameter int D1 = COORD_BITS + 1,
    parameter int D2 = 2 * COORD_BITS + 3,
    parameter int FW = 12 * D1 + 6 * D2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  stiu_pkg::t_in_item i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [FW-1:0]      o_data
);

    localparam int PW = 2 * D1;

    logic [63:0]                  raw [5];
    logic signed [COORD_BITS-1:0] pt [5][3];
    logic signed [D1-1:0]         n_vec [4][3];
    logic signed [D1-1:0]         r_vec [4][3];
    logic signed [D1-1:0]         r_vec2 [4][3];
    logic signed [D2-1:0]         n_nrm [3];
    logic signed [D2-1:0]         n_ecr [3];
    logic signed [D2-1:0]         r_nrm [3];
    logic signed [D2-1:0]         r_ecr [3];
    logic                         r_v1, r_v2;
    logic                         rdy1, rdy2;

    // elastic handshake through two stages
    assign rdy2    = !r_v2 || i_ready;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v2;

    // unpack points: start, end, a, b, c
    always_comb begin
        raw[0] = 64'(i_data.seg_start);
        raw[1] = 64'(i_data.seg_end);
        raw[2] = 64'(i_data.vert_a);
        raw[3] = 64'(i_data.vert_b);
        raw[4] = 64'(i_data.vert_c);
        for (int f = 0; f < 5; f++) begin
            for (int k = 0; k < 3; k++) begin
                pt[f][k] = raw[f][k*COORD_BITS +: COORD_BITS];
            end
        end
    end

    // edge vectors ab, ac, qp, ap
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_vec[0][k] = D1'(pt[3][k]) - D1'(pt[2][k]);
            n_vec[1][k] = D1'(pt[4][k]) - D1'(pt[2][k]);
            n_vec[2][k] = D1'(pt[0][k]) - D1'(pt[1][k]);
            n_vec[3][k] = D1'(pt[0][k]) - D1'(pt[2][k]);
        end
    end

    // cross products n = ab x ac and e = qp x ap
    always_comb begin
        logic signed [PW-1:0] pa, pb, pc, pd;
        for (int k = 0; k < 3; k++) begin
            pa = r_vec[0][(k+1)%3] * r_vec[1][(k+2)%3];
            pb = r_vec[0][(k+2)%3] * r_vec[1][(k+1)%3];
            pc = r_vec[2][(k+1)%3] * r_vec[3][(k+2)%3];
            pd = r_vec[2][(k+2)%3] * r_vec[3][(k+1)%3];
            n_nrm[k] = D2'(pa) - D2'(pb);
            n_ecr[k] = D2'(pc) - D2'(pd);
        end
    end

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) r_vec <= n_vec;
        if (rdy2 && r_v1) begin
            r_vec2 <= r_vec;
            r_nrm  <= n_nrm;
            r_ecr  <= n_ecr;
        end
    end

    // pack for the queue: ab, ac, qp, ap, n, e
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 4; j++) begin
                o_data[(j*3+k)*D1 +: D1] = r_vec2[j][k];
            end
            o_data[12*D1 + k*D2 +: D2]       = r_nrm[k];
            o_data[12*D1 + (3+k)*D2 +: D2]   = r_ecr[k];
        end
    end

endmodule

@@ rtl/stiu_fifo.sv @@
// short register queue between the front and back parts
// no dependencies
`timescale 1ns / 1ps
module stiu_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [AW:0]      r_cnt;
    logic             wr_en, rd_en;

    assign o_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign wr_en   = i_valid && o_ready;
    assign rd_en   = o_valid && i_ready;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) r_wr <= (r_wr == AW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            if (rd_en) r_rd <= (r_rd == AW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            if (wr_en && !rd_en) r_cnt <= r_cnt + 1'b1;
            else if (rd_en && !wr_en) r_cnt <= r_cnt - 1'b1;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_wr] <= i_data;
    end

endmodule

@@ rtl/stiu_back.sv @@
// back part: dot products, inside tests and pipelined restoring divider
// depends on stiu_pkg
`timescale 1ns / 1ps
module stiu_back #(
    parameter int COORD_BITS = 16,
    parameter int D1 = COORD_BITS + 1,
    parameter int D2 = 2 * COORD_BITS + 3,
    parameter int FW = 12 * D1 + 6 * D2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [FW-1:0]       i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output stiu_pkg::t_out_item o_data
);

    localparam int FB = stiu_pkg::FRACTION_BITS;
    localparam int PW = D1 + D2;
    localparam int DW = 3 * COORD_BITS + 6;
    localparam int NS = FB + 3;

    logic signed [D1-1:0] vec [4][3];
    logic signed [D2-1:0] nrm [3];
    logic signed [D2-1:0] ecr [3];
    logic signed [PW-1:0] n_prod [4][3];
    logic signed [PW-1:0] r_prod [4][3];
    logic signed [DW-1:0] s_d, s_t, s_v, s_w;
    logic signed [DW:0]   s_vw;
    logic                 n_hit;
    logic                 r_hit2;
    logic [DW-1:0]        r_t2, r_d2;
    logic [DW-1:0]        r_rem [FB+1];
    logic [DW-1:0]        r_div [FB+1];
    logic [FB:0]          r_quo [FB+1];
    logic                 r_hq  [FB+1];
    logic [NS-1:0]        r_v;
    logic [NS-1:0]        rdy;

    // elastic handshake along the whole back pipeline
    always_comb begin
        rdy[NS-1] = !r_v[NS-1] || i_ready;
        for (int s = NS - 2; s >= 0; s--) begin
            rdy[s] = !r_v[s] || rdy[s+1];
        end
    end
    assign o_ready = rdy[0];
    assign o_valid = r_v[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) r_v[0] <= i_valid;
            for (int s = 1; s < NS; s++) begin
                if (rdy[s]) r_v[s] <= r_v[s-1];
            end
        end
    end

    // unpack queue entry and form the dot product terms
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 4; j++) begin
                vec[j][k] = i_data[(j*3+k)*D1 +: D1];
            end
            nrm[k] = i_data[12*D1 + k*D2 +: D2];
            ecr[k] = i_data[12*D1 + (3+k)*D2 +: D2];
        end
        for (int k = 0; k < 3; k++) begin
            n_prod[0][k] = vec[2][k] * nrm[k];
            n_prod[1][k] = vec[3][k] * nrm[k];
            n_prod[2][k] = vec[1][k] * ecr[k];
            n_prod[3][k] = vec[0][k] * ecr[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0] && i_valid) r_prod <= n_prod;
    end

    // sums and inside tests, boundaries inclusive
    always_comb begin
        s_d  = DW'(r_prod[0][0]) + DW'(r_prod[0][1]) + DW'(r_prod[0][2]);
        s_t  = DW'(r_prod[1][0]) + DW'(r_prod[1][1]) + DW'(r_prod[1][2]);
        s_v  = DW'(r_prod[2][0]) + DW'(r_prod[2][1]) + DW'(r_prod[2][2]);
        s_w  = -(DW'(r_prod[3][0]) + DW'(r_prod[3][1]) + DW'(r_prod[3][2]));
        s_vw = (DW+1)'(s_v) + (DW+1)'(s_w);
        n_hit = (s_d > 0) && (s_t >= 0) && (s_t <= s_d) && (s_v >= 0)
             && (s_v <= s_d) && (s_w >= 0) && (s_vw <= (DW+1)'(s_d));
    end

    always_ff @(posedge i_clk) begin
        if (rdy[1] && r_v[0]) begin
            r_hit2 <= n_hit;
            r_t2   <= s_t;
            r_d2   <= s_d;
        end
    end

    // divider, one quotient bit per stage; first stage takes the integer bit
    always_ff @(posedge i_clk) begin
        logic [DW-1:0] rs;
        logic          ge;
        if (rdy[2] && r_v[1]) begin
            ge          = (r_t2 >= r_d2);
            r_rem[0]   <= ge ? r_t2 - r_d2 : r_t2;
            r_div[0]   <= r_d2;
            r_quo[0]   <= (FB+1)'(ge);
            r_hq[0]    <= r_hit2;
        end
        for (int s = 1; s <= FB; s++) begin
            if (rdy[s+2] && r_v[s+1]) begin
                rs        = r_rem[s-1] << 1;
                ge        = (rs >= r_div[s-1]);
                r_rem[s] <= ge ? rs - r_div[s-1] : rs;
                r_div[s] <= r_div[s-1];
                r_quo[s] <= {r_quo[s-1][FB-1:0], ge};
                r_hq[s]  <= r_hq[s-1];
            end
        end
    end

    // result, fraction forced to zero on a miss
    assign o_data.hit          = r_hq[FB];
    assign o_data.hit_fraction = r_hq[FB] ? r_quo[FB] : '0;

`ifndef ASSERT_OFF
    // a hit passed to the divider always has 0 <= t <= d
    a_div_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[1] && r_hit2 |-> (r_t2 <= r_d2))
        else $error("divider operand out of range");

    // fraction never exceeds one
    a_frac_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.hit_fraction <= (FB+1)'(1) << FB))
        else $error("hit fraction above one");

    // a stalled result stays in place until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed under stall");
`endif

endmodule

@@ rtl/segment_triangle_intersect_unit.sv @@
// segment / triangle intersection unit: input channel -> front stages -> queue
// -> back stages -> result channel; depends on stiu_pkg, stiu_front,
// stiu_fifo and stiu_back
//
// usage:
//   input transaction: segment start/end and triangle vertices a, b, c, each a
//   packed signed x/y/z point; accepted when i_in_valid and o_in_ready are high
//   result transaction: hit flag and hit_fraction = floor(2^16 * t / d), zero on
//   a miss (parallel, back facing, degenerate or outside); one per input
//   stages: 2 front stages, the queue write, 2 back stages for dot products
//   and tests, 17 divider stages (one quotient bit per stage)
//   throughput: one transaction per cycle while the receiver does not stall;
//   the divider is fully pipelined
//   receiver stall: each stage holds its item, the 4-entry queue absorbs the
//   front output, and o_in_ready falls once the front stages are full
//   reset: synchronous, active low; clears all valid flags and the queue
`timescale 1ns / 1ps
module segment_triangle_intersect_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  stiu_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output stiu_pkg::t_out_item o_out_data
);

    localparam int COORD_BITS = stiu_pkg::COORD_BITS;
    localparam int D1 = COORD_BITS + 1;
    localparam int D2 = 2 * COORD_BITS + 3;
    localparam int FW = 12 * D1 + 6 * D2;

    logic          f_valid, f_ready, q_valid, q_ready;
    logic [FW-1:0] f_data, q_data;

    // classify: differences and cross products
    stiu_front #(.COORD_BITS(COORD_BITS), .D1(D1), .D2(D2), .FW(FW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_data  (f_data)
    );

    // decoupling queue
    stiu_fifo #(.WIDTH(FW), .DEPTH(4)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (f_data),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_data)
    );

    // dot products, tests and division
    stiu_back #(.COORD_BITS(COORD_BITS), .D1(D1), .D2(D2), .FW(FW)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_data  (q_data),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule
